/* rtl/mapcd_pkg.sv */
package mapcd_pkg;

  // Agent lanes and location widths
  localparam int MAX_AGENTS    = 8;
  localparam int AGENT_W       = $clog2(MAX_AGENTS);
  localparam int LOCATION_BITS = 16;
  localparam int LOC_W         = 16;
  localparam logic [LOC_W-1:0] LOC_MASK = LOC_W'((64'd1 << LOCATION_BITS) - 64'd1);

  // Config, time and count widths
  localparam int CFG_W   = 4;
  localparam int TIME_W  = 16;
  localparam int COUNT_W = 24;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One lane sees at most 3 * (MAX_AGENTS - 1) hits per request
  localparam int LANE_CNT_W = $clog2(3 * (MAX_AGENTS - 1) + 1);
  localparam int STEP_CNT_W = LANE_CNT_W + AGENT_W;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_VERTEX = 2'd1,
    KIND_EDGE   = 2'd2
  } kind_t;

  // What one lane found for its lower agent
  typedef struct packed {
    logic                  hit1;
    kind_t                 kind1;
    logic [AGENT_W-1:0]    j1;
    logic [LOC_W-1:0]      from1;
    logic [LOC_W-1:0]      to1;
    logic                  hit2;
    logic [AGENT_W-1:0]    j2;
    logic [LOC_W-1:0]      from2;
    logic [LANE_CNT_W-1:0] cnt;
  } lane_res_t;

endpackage

/* rtl/mapcd_lane.sv */
module mapcd_lane (
  input  logic [mapcd_pkg::AGENT_W-1:0]    lane_idx,
  input  logic [mapcd_pkg::LOC_W-1:0]      cur [mapcd_pkg::MAX_AGENTS],
  input  logic [mapcd_pkg::LOC_W-1:0]      nxt [mapcd_pkg::MAX_AGENTS],
  input  logic [mapcd_pkg::MAX_AGENTS-1:0] pair_en,
  input  logic                             check_move,
  input  logic                             check_final,
  output mapcd_pkg::lane_res_t             res
);

  logic [mapcd_pkg::MAX_AGENTS-1:0] vld;
  logic [mapcd_pkg::MAX_AGENTS-1:0] vtx1;
  logic [mapcd_pkg::MAX_AGENTS-1:0] edg1;
  logic [mapcd_pkg::MAX_AGENTS-1:0] vtx2;
  logic [mapcd_pkg::LOC_W-1:0]      cur_i;
  logic [mapcd_pkg::LOC_W-1:0]      nxt_i;
  logic                             moved;

  // Compare this lane's agent against every higher agent in use
  always_comb begin
    cur_i = cur[lane_idx];
    nxt_i = nxt[lane_idx];
    moved = cur_i != nxt_i;
    for (int j = 0; j < mapcd_pkg::MAX_AGENTS; j++) begin
      vld[j]  = pair_en[j] && (mapcd_pkg::AGENT_W'(j) > lane_idx);
      vtx1[j] = vld[j] && check_move && (cur_i == cur[j]);
      edg1[j] = vld[j] && check_move && moved && (cur_i == nxt[j]) && (nxt_i == cur[j]);
      vtx2[j] = vld[j] && check_final && (nxt_i == nxt[j]);
    end
  end

  // Pick the first hit in pair order, vertex ahead of swap; count all hits
  always_comb begin
    res = '0;
    for (int j = mapcd_pkg::MAX_AGENTS - 1; j >= 0; j--) begin
      if (edg1[j]) begin
        res.hit1  = 1'b1;
        res.kind1 = mapcd_pkg::KIND_EDGE;
        res.j1    = mapcd_pkg::AGENT_W'(j);
        res.from1 = cur_i;
        res.to1   = nxt_i;
      end
      if (vtx1[j]) begin
        res.hit1  = 1'b1;
        res.kind1 = mapcd_pkg::KIND_VERTEX;
        res.j1    = mapcd_pkg::AGENT_W'(j);
        res.from1 = cur_i;
        res.to1   = '0;
      end
      if (vtx2[j]) begin
        res.hit2 = 1'b1;
        res.j2   = mapcd_pkg::AGENT_W'(j);
      end
    end
    res.from2 = nxt_i;
    for (int j = 0; j < mapcd_pkg::MAX_AGENTS; j++) begin
      res.cnt = res.cnt + mapcd_pkg::LANE_CNT_W'(vtx1[j])
              + mapcd_pkg::LANE_CNT_W'(edg1[j]) + mapcd_pkg::LANE_CNT_W'(vtx2[j]);
    end
  end

endmodule

/* rtl/mapcd_merge.sv */
module mapcd_merge (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s1_valid,
  input  logic                               s1_last,
  input  logic [mapcd_pkg::TIME_W-1:0]       s1_t1,
  input  logic [mapcd_pkg::TIME_W-1:0]       s1_t2,
  input  mapcd_pkg::lane_res_t               s1_res [mapcd_pkg::MAX_AGENTS],
  output logic                               s1_take,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         conflict_kind,
  output logic [mapcd_pkg::TIME_W-1:0]       conflict_time,
  output logic [mapcd_pkg::AGENT_W-1:0]      agent_first,
  output logic [mapcd_pkg::AGENT_W-1:0]      agent_second,
  output logic [mapcd_pkg::LOC_W-1:0]        location_from,
  output logic [mapcd_pkg::LOC_W-1:0]        location_to,
  output logic [mapcd_pkg::COUNT_W-1:0]      conflict_count
);

  mapcd_pkg::kind_t                  found_kind;
  logic [mapcd_pkg::TIME_W-1:0]      found_time;
  logic [mapcd_pkg::AGENT_W-1:0]     found_i;
  logic [mapcd_pkg::AGENT_W-1:0]     found_j;
  logic [mapcd_pkg::LOC_W-1:0]       found_from;
  logic [mapcd_pkg::LOC_W-1:0]       found_to;
  logic [mapcd_pkg::COUNT_W-1:0]     running_count;

  mapcd_pkg::kind_t                  kind_next;
  logic [mapcd_pkg::TIME_W-1:0]      time_next;
  logic [mapcd_pkg::AGENT_W-1:0]     i_next;
  logic [mapcd_pkg::AGENT_W-1:0]     j_next;
  logic [mapcd_pkg::LOC_W-1:0]       from_next;
  logic [mapcd_pkg::LOC_W-1:0]       to_next;
  logic [mapcd_pkg::COUNT_W-1:0]     count_next;

  mapcd_pkg::kind_t                  step_kind;
  logic [mapcd_pkg::TIME_W-1:0]      step_time;
  logic [mapcd_pkg::AGENT_W-1:0]     step_i;
  logic [mapcd_pkg::AGENT_W-1:0]     step_j;
  logic [mapcd_pkg::LOC_W-1:0]       step_from;
  logic [mapcd_pkg::LOC_W-1:0]       step_to;
  logic [mapcd_pkg::STEP_CNT_W-1:0]  step_cnt;
  logic [mapcd_pkg::COUNT_W:0]       count_sum;
  logic                              hit1_any;
  logic                              hit2_any;
  logic [mapcd_pkg::AGENT_W-1:0]     pick1;
  logic [mapcd_pkg::AGENT_W-1:0]     pick2;
  mapcd_pkg::kind_t                  out_kind;

  // Take a request unless it carries a result and the output is still held
  assign s1_take = s1_valid && (!s1_last || !out_valid || !out_stall);

  // Find the lowest lane with a hit and sum the lane counts
  always_comb begin
    hit1_any = 1'b0;
    hit2_any = 1'b0;
    pick1    = '0;
    pick2    = '0;
    step_cnt = '0;
    for (int i = mapcd_pkg::MAX_AGENTS - 1; i >= 0; i--) begin
      if (s1_res[i].hit1) begin
        hit1_any = 1'b1;
        pick1    = mapcd_pkg::AGENT_W'(i);
      end
      if (s1_res[i].hit2) begin
        hit2_any = 1'b1;
        pick2    = mapcd_pkg::AGENT_W'(i);
      end
    end
    for (int i = 0; i < mapcd_pkg::MAX_AGENTS; i++) begin
      step_cnt = step_cnt + mapcd_pkg::STEP_CNT_W'(s1_res[i].cnt);
    end
  end

  // Step's first conflict: moves ahead of the final hold pass
  always_comb begin
    step_kind = mapcd_pkg::KIND_NONE;
    step_time = '0;
    step_i    = '0;
    step_j    = '0;
    step_from = '0;
    step_to   = '0;
    if (hit1_any) begin
      step_kind = s1_res[pick1].kind1;
      step_time = s1_t1;
      step_i    = pick1;
      step_j    = s1_res[pick1].j1;
      step_from = s1_res[pick1].from1;
      step_to   = s1_res[pick1].to1;
    end else if (hit2_any) begin
      step_kind = mapcd_pkg::KIND_VERTEX;
      step_time = s1_t2;
      step_i    = pick2;
      step_j    = s1_res[pick2].j2;
      step_from = s1_res[pick2].from2;
    end
  end

  // Keep the earliest conflict; saturate the count
  always_comb begin
    if (found_kind != mapcd_pkg::KIND_NONE) begin
      kind_next = found_kind;
      time_next = found_time;
      i_next    = found_i;
      j_next    = found_j;
      from_next = found_from;
      to_next   = found_to;
    end else begin
      kind_next = step_kind;
      time_next = step_time;
      i_next    = step_i;
      j_next    = step_j;
      from_next = step_from;
      to_next   = step_to;
    end
    count_sum  = {1'b0, running_count} + (mapcd_pkg::COUNT_W + 1)'(step_cnt);
    count_next = count_sum[mapcd_pkg::COUNT_W] ? mapcd_pkg::COUNT_MAX
                                               : count_sum[mapcd_pkg::COUNT_W-1:0];
  end

  // Advance the running record; clear it once the result is loaded
  always_ff @(posedge clk) begin
    if (rst || (s1_take && s1_last)) begin
      found_kind    <= mapcd_pkg::KIND_NONE;
      found_time    <= '0;
      found_i       <= '0;
      found_j       <= '0;
      found_from    <= '0;
      found_to      <= '0;
      running_count <= '0;
    end else if (s1_take) begin
      found_kind    <= kind_next;
      found_time    <= time_next;
      found_i       <= i_next;
      found_j       <= j_next;
      found_from    <= from_next;
      found_to      <= to_next;
      running_count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_last) begin
      out_kind       <= kind_next;
      conflict_time  <= time_next;
      agent_first    <= i_next;
      agent_second   <= j_next;
      location_from  <= from_next;
      location_to    <= to_next;
      conflict_count <= count_next;
    end
  end

  assign conflict_kind = out_kind;

  // A reported pair is always ordered
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind != mapcd_pkg::KIND_NONE) |-> agent_first < agent_second)
    else $error("conflict pair out of order");

  // A reported conflict was counted
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind != mapcd_pkg::KIND_NONE) |-> conflict_count != '0)
    else $error("conflict reported with zero count");

  // No conflict leaves the detail fields clear
  a_none_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == mapcd_pkg::KIND_NONE) |->
      (conflict_time == '0) && (agent_first == '0) && (agent_second == '0) &&
      (location_from == '0) && (location_to == '0))
    else $error("detail fields set without a conflict");

  // A vertex conflict has no edge target
  a_vertex_to: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == mapcd_pkg::KIND_VERTEX) |-> location_to == '0)
    else $error("vertex conflict with edge target");

endmodule

/* rtl/multi_agent_path_conflict_detect_unit.sv */
// Multi-agent path conflict detector.
// Input channel (in_valid / in_stall): one request per time step, carrying
// every agent's location and an active mask; a clear mask bit holds that
// agent at its previous location. last_step marks the final step of a set
// of paths. Requests are taken at one per cycle while in_stall is low.
// Output channel (out_valid / out_stall): one result per set of paths, on the
// request with last_step set: the first vertex or swap conflict and the
// saturating total. out_valid rises once that request has passed the stage
// register and the merge. Steps without last_step give no result.
// Each agent lane compares its agent with every higher agent; the stage
// register holds the lane results, and the merge picks the first conflict
// and sums the counts, so throughput is one request per cycle unless stalled.
// cfg_write_enable / cfg_write_data set the number of agents in use (reset 8);
// write it only while the block is idle.
// Reset clears all path state and out_valid. While a result is
// held by out_stall, further steps are still taken; a second last_step
// request waits in the merge stage, and in_stall rises behind it.
module multi_agent_path_conflict_detect_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic [mapcd_pkg::CFG_W-1:0]     cfg_write_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mapcd_pkg::LOC_W-1:0]     location_0,
  input  logic [mapcd_pkg::LOC_W-1:0]     location_1,
  input  logic [mapcd_pkg::LOC_W-1:0]     location_2,
  input  logic [mapcd_pkg::LOC_W-1:0]     location_3,
  input  logic [mapcd_pkg::LOC_W-1:0]     location_4,
  input  logic [mapcd_pkg::LOC_W-1:0]     location_5,
  input  logic [mapcd_pkg::LOC_W-1:0]     location_6,
  input  logic [mapcd_pkg::LOC_W-1:0]     location_7,
  input  logic [mapcd_pkg::MAX_AGENTS-1:0] active_mask,
  input  logic                            last_step,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      conflict_kind,
  output logic [mapcd_pkg::TIME_W-1:0]    conflict_time,
  output logic [mapcd_pkg::AGENT_W-1:0]   agent_first,
  output logic [mapcd_pkg::AGENT_W-1:0]   agent_second,
  output logic [mapcd_pkg::LOC_W-1:0]     location_from,
  output logic [mapcd_pkg::LOC_W-1:0]     location_to,
  output logic [mapcd_pkg::COUNT_W-1:0]   conflict_count
);

  logic [mapcd_pkg::CFG_W-1:0]      agent_count;
  logic [mapcd_pkg::LOC_W-1:0]      loc_in [mapcd_pkg::MAX_AGENTS];
  logic [mapcd_pkg::LOC_W-1:0]      prev_loc [mapcd_pkg::MAX_AGENTS];
  logic [mapcd_pkg::LOC_W-1:0]      now_loc [mapcd_pkg::MAX_AGENTS];
  logic                             have_prev;
  logic [mapcd_pkg::TIME_W-1:0]     step_time;
  logic [mapcd_pkg::TIME_W-1:0]     time_inc;
  logic [mapcd_pkg::TIME_W-1:0]     time_final;
  logic [mapcd_pkg::MAX_AGENTS-1:0] pair_en;
  logic                             in_take;

  mapcd_pkg::lane_res_t             lane_res [mapcd_pkg::MAX_AGENTS];
  mapcd_pkg::lane_res_t             s1_res [mapcd_pkg::MAX_AGENTS];
  logic                             s1_valid;
  logic                             s1_last;
  logic [mapcd_pkg::TIME_W-1:0]     s1_t1;
  logic [mapcd_pkg::TIME_W-1:0]     s1_t2;
  logic                             s1_take;

  assign loc_in[0] = location_0;
  assign loc_in[1] = location_1;
  assign loc_in[2] = location_2;
  assign loc_in[3] = location_3;
  assign loc_in[4] = location_4;
  assign loc_in[5] = location_5;
  assign loc_in[6] = location_6;
  assign loc_in[7] = location_7;

  // Agent count register
  always_ff @(posedge clk) begin
    if (rst) begin
      agent_count <= mapcd_pkg::CFG_W'(mapcd_pkg::MAX_AGENTS);
    end else if (cfg_write_enable) begin
      agent_count <= cfg_write_data;
    end
  end

  // Stall when the stage register is full and cannot drain
  assign in_stall = s1_valid && !s1_take;
  assign in_take  = in_valid && !in_stall;

  // Apply the hold rule and the enabled agent set
  always_comb begin
    for (int k = 0; k < mapcd_pkg::MAX_AGENTS; k++) begin
      now_loc[k] = active_mask[k] ? (loc_in[k] & mapcd_pkg::LOC_MASK) : prev_loc[k];
      pair_en[k] = mapcd_pkg::CFG_W'(k) < agent_count;
    end
    time_inc   = (step_time == mapcd_pkg::TIME_MAX) ? step_time
                                                    : step_time + mapcd_pkg::TIME_W'(1);
    time_final = have_prev ? time_inc : step_time;
  end

  // Path state: hold previous locations and the step time
  always_ff @(posedge clk) begin
    if (rst || (in_take && last_step)) begin
      for (int k = 0; k < mapcd_pkg::MAX_AGENTS; k++) begin
        prev_loc[k] <= '0;
      end
      have_prev <= 1'b0;
      step_time <= '0;
    end else if (in_take) begin
      for (int k = 0; k < mapcd_pkg::MAX_AGENTS; k++) begin
        prev_loc[k] <= now_loc[k];
      end
      have_prev <= 1'b1;
      step_time <= time_final;
    end
  end

  // One lane per agent
  for (genvar g = 0; g < mapcd_pkg::MAX_AGENTS; g++) begin : g_lane
    mapcd_lane u_lane (
      .lane_idx    (mapcd_pkg::AGENT_W'(g)),
      .cur         (prev_loc),
      .nxt         (now_loc),
      .pair_en     (pair_en),
      .check_move  (have_prev),
      .check_final (last_step),
      .res         (lane_res[g])
    );
  end

  // Stage register between the lanes and the merge
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_last <= last_step;
      s1_t1   <= step_time;
      s1_t2   <= time_final;
      for (int k = 0; k < mapcd_pkg::MAX_AGENTS; k++) begin
        s1_res[k] <= lane_res[k];
      end
    end
  end

  mapcd_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .s1_valid       (s1_valid),
    .s1_last        (s1_last),
    .s1_t1          (s1_t1),
    .s1_t2          (s1_t2),
    .s1_res         (s1_res),
    .s1_take        (s1_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .conflict_kind  (conflict_kind),
    .conflict_time  (conflict_time),
    .agent_first    (agent_first),
    .agent_second   (agent_second),
    .location_from  (location_from),
    .location_to    (location_to),
    .conflict_count (conflict_count)
  );

endmodule
